/* src/bpes_pkg.sv */
// ----------------------------------------------------------------------------
// bpes_pkg
// Shared types and constants of the Buckingham pair energy summer.
// ----------------------------------------------------------------------------
package bpes_pkg;

  localparam int unsigned MAX_ATOMS  = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_ATOMS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned WORD_W     = 3 * COORD_W + 1;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned ENERGY_W   = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // divider: dividend up to 2^48 with 32 added fraction bits
  localparam int unsigned DIV_W   = 81;
  localparam int unsigned REM_W   = 40;
  localparam int unsigned QUO_W   = 49;
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_END    = 2'd2;

  localparam logic [COORD_W-1:0] BOX_RESET = 24'hFF_FFFF;
  localparam logic [ROW_W-1:0]   ROW_END_RESET = 11'd1024;

  localparam logic [COORD_W-1:0] CUT_AXIS = 24'(6 << 16);
  localparam logic [REM_W-1:0]   CUT_SQ   = 40'h24_0000_0000;
  localparam logic [QUO_W-1:0]   D_CAP    = 49'h1_0000_0000_0000;

  localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
  localparam logic [63:0] P_OO  =
    (64'd20292204 * 64'd964993 * 64'd65536 + 64'd50000000) / 64'd100000000;
  localparam logic [63:0] P_SIO =
    (64'd13702905 * 64'd964993 * 64'd65536 + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] C_OO  =
    (64'd19258 * 64'd964993 * 64'd65536 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] C_SIO =
    (64'd54681 * 64'd964993 * 64'd65536 + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] K_OO  = (LOG2E_Q32 * 64'd1000000 + 64'd171822) / 64'd343645;
  localparam logic [63:0] K_SIO = (LOG2E_Q32 * 64'd1000000 + 64'd96908) / 64'd193817;

  typedef logic [31:0] hp_tab_t [33];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bits;
    v    = v_in;
    res  = '0;
    bits = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (v >= res + bits) begin
        v   = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // factors 2^(-2^-k) in Q.31, elaboration only
  function automatic hp_tab_t build_half_pow();
    hp_tab_t t;
    logic [63:0] h;
    t[0] = 32'h8000_0000;
    h    = isqrt64(64'd1 << 61);
    t[1] = h[31:0];
    for (int k = 2; k <= 32; k++) begin
      h    = isqrt64({1'b0, h[31:0], 31'd0});
      t[k] = h[31:0];
    end
    return t;
  endfunction

  localparam hp_tab_t HALF_POW = build_half_pow();

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROW,
    S_ROW_LATCH,
    S_COL,
    S_PAIR,
    S_GAP,
    S_FOLD,
    S_GAP_CHK,
    S_GAP_ACC,
    S_R_CHK,
    S_SQRT,
    S_Z_LO,
    S_Z_HI,
    S_Z_SUM,
    S_EXP,
    S_EXP_UPD,
    S_F_LO,
    S_F_HI,
    S_F_SUM,
    S_D_NEXT,
    S_ACC,
    S_MUL,
    S_DIV,
    S_DONE
  } seq_state_e;

endpackage

/* src/bpes_if.sv */
// ----------------------------------------------------------------------------
// bpes_if
// Handshake channels of the Buckingham pair energy summer.
// ----------------------------------------------------------------------------
interface bpes_atom_if;
  logic                        valid;
  logic                        ready;
  logic [bpes_pkg::COORD_W-1:0] pos_x;
  logic [bpes_pkg::COORD_W-1:0] pos_y;
  logic [bpes_pkg::COORD_W-1:0] pos_z;
  logic                        species;
  logic                        last_atom;
  modport source (output valid, pos_x, pos_y, pos_z, species, last_atom, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, species, last_atom, output ready);
endinterface

interface bpes_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [bpes_pkg::ENERGY_W-1:0] energy;
  logic                                saturated;
  modport source (output valid, energy, saturated, input ready);
  modport sink   (input valid, energy, saturated, output ready);
endinterface

interface bpes_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpes_pkg::CFG_IDX_W-1:0]  index;
  logic [bpes_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/bpes_ram.sv */
// ----------------------------------------------------------------------------
// bpes_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/buckingham_pair_energy_sum.sv */
// ----------------------------------------------------------------------------
// buckingham_pair_energy_sum
// Buckingham pair energy total over a periodic cubic box.
// ----------------------------------------------------------------------------
// Usage:
//   atom_i   : one word per atom (Q8.16 position, species, last_atom). Ready is
//              high only while the block waits for atoms; each atom is
//              written to the atom RAM (dropped when it is full).
//   result_o : one word per set, sent after the word carrying last_atom.
//   cfg_i    : register writes, always ready; write only while idle.
//   After the last atom, each outer row passes S_ROW, S_ROW_LATCH and S_COL,
//   then its pairs. A pair skipped on species or saturation, dropped on the
//   cutoff or saturating the total at zero distance ends early; a full pair
//   is paced by the one bit-serial divider (three 81-step divisions and up
//   to three 24-step folds) and the 32-step exponent walk over the shared
//   32x32 multiplier.
//   Throughput: one set at a time; atoms of the next set are taken as soon
//   as the result sits in the output register.
//   Reset empties the set, clears the total and loads register defaults.
//   A stalled receiver holds the result; a following set waits at its end.
// ----------------------------------------------------------------------------
module buckingham_pair_energy_sum (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpes_atom_if.sink     atom_i,
  bpes_result_if.source result_o,
  bpes_cfg_if.sink      cfg_i
);

  localparam int unsigned CW = bpes_pkg::COORD_W;

  bpes_pkg::seq_state_e state_q, state_d, ret_q, ret_d;

  logic [bpes_pkg::CNT_W-1:0]    loaded_q, loaded_d, i_q, i_d, j_q, j_d, end_w;
  logic [bpes_pkg::ENERGY_W-1:0] sum_q, sum_d, energy_q, energy_d;
  logic                          sat_q, sat_d, out_valid_q, out_valid_d;
  logic                          sat_out_q, sat_out_d;
  logic [CW-1:0]                 box_q, box_d;
  logic [bpes_pkg::ROW_W-1:0]    row_first_q, row_first_d, row_end_q, row_end_d;

  logic [bpes_pkg::WORD_W-1:0]   ai_q, ai_d, aj_q, aj_d, ram_rdata, ram_wdata;
  logic [bpes_pkg::IDX_W-1:0]    ram_raddr;
  logic                          ram_we;
  logic                          oo_q, oo_d;
  logic [1:0]                    axis_q, axis_d, dcnt_q, dcnt_d;
  logic [CW-1:0]                 gap_q, gap_d, ga, gb, gdiff, grem;
  logic [bpes_pkg::REM_W-1:0]    r2_q, r2_d;
  logic [53:0]                   sq_v_q, sq_v_d;
  logic [55:0]                   sq_res_q, sq_res_d, sq_bit_q, sq_bit_d, sq_sum;
  logic [4:0]                    sq_cnt_q, sq_cnt_d;
  logic [63:0]                   acc_q, acc_d, prod_q, full_w, e_q, e_d;
  logic [5:0]                    n_q, n_d, k_q, k_d;
  logic [31:0]                   f_q, f_d, m_q, m_d, mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [6:0]                    shamt;
  logic [bpes_pkg::QUO_W-1:0]    d_q, d_d, quo_cap;
  logic [bpes_pkg::DIV_W-1:0]    div_n_q, div_n_d;
  logic [bpes_pkg::REM_W-1:0]    div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [bpes_pkg::REM_W:0]      div_trial;
  logic [bpes_pkg::QUO_W-1:0]    div_quo_q, div_quo_d;
  logic                          div_ovf_q, div_ovf_d;
  logic [bpes_pkg::DCNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic signed [65:0]            term_w, sumx_w, snew_w;
  logic [63:0]                   k_sel, p_sel;

  localparam logic signed [65:0] MIN66 = {{19{1'b1}}, 47'd0};
  localparam logic signed [65:0] MAX66 = {19'd0, {47{1'b1}}};

  assign end_w = (bpes_pkg::CNT_W'(row_end_q) < loaded_q) ?
                 bpes_pkg::CNT_W'(row_end_q) : loaded_q;

  assign k_sel = oo_q ? bpes_pkg::K_OO : bpes_pkg::K_SIO;
  assign p_sel = oo_q ? bpes_pkg::P_OO : bpes_pkg::P_SIO;

  assign ga    = ai_q[axis_q*CW +: CW];
  assign gb    = aj_q[axis_q*CW +: CW];
  assign gdiff = (ga > gb) ? ga - gb : gb - ga;
  assign grem  = div_rem_q[CW-1:0];

  assign sq_sum    = {2'b00, sq_v_q} ;
  assign div_trial = {div_rem_q, div_n_q[bpes_pkg::DIV_W-1]};
  assign quo_cap   = (div_ovf_q || div_quo_q[bpes_pkg::QUO_W-1]) ? bpes_pkg::D_CAP
                                                                 : div_quo_q;
  assign full_w    = acc_q + {prod_q[31:0], 32'd0};
  assign shamt     = 7'(n_q) + 7'd26;

  assign term_w = $signed({2'b00, e_q}) - $signed({17'd0, d_q});
  assign sumx_w = $signed({{18{sum_q[bpes_pkg::ENERGY_W-1]}}, sum_q});
  assign snew_w = sumx_w + term_w;

  assign atom_i.ready = (state_q == bpes_pkg::S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign result_o.valid     = out_valid_q;
  assign result_o.energy    = energy_q;
  assign result_o.saturated = sat_out_q;

  assign ram_we    = atom_i.valid && (state_q == bpes_pkg::S_IDLE) &&
                     (loaded_q < bpes_pkg::CNT_W'(bpes_pkg::MAX_ATOMS));
  assign ram_wdata = {atom_i.species, atom_i.pos_z, atom_i.pos_y, atom_i.pos_x};

  bpes_ram #(
    .WIDTH (bpes_pkg::WORD_W),
    .DEPTH (bpes_pkg::MAX_ATOMS)
  ) u_atoms (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (loaded_q[bpes_pkg::IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    loaded_d    = loaded_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    energy_d    = energy_q;
    sat_out_d   = sat_out_q;
    box_d       = box_q;
    row_first_d = row_first_q;
    row_end_d   = row_end_q;
    i_d         = i_q;
    j_d         = j_q;
    ai_d        = ai_q;
    aj_d        = aj_q;
    oo_d        = oo_q;
    axis_d      = axis_q;
    dcnt_d      = dcnt_q;
    gap_d       = gap_q;
    r2_d        = r2_q;
    sq_v_d      = sq_v_q;
    sq_res_d    = sq_res_q;
    sq_bit_d    = sq_bit_q;
    sq_cnt_d    = sq_cnt_q;
    acc_d       = acc_q;
    n_d         = n_q;
    f_d         = f_q;
    m_d         = m_q;
    k_d         = k_q;
    e_d         = e_q;
    d_d         = d_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    div_n_d     = div_n_q;
    div_rem_d   = div_rem_q;
    div_den_d   = div_den_q;
    div_quo_d   = div_quo_q;
    div_ovf_d   = div_ovf_q;
    div_cnt_d   = div_cnt_q;
    ram_raddr   = j_q[bpes_pkg::IDX_W-1:0];

    if (cfg_i.valid) begin
      case (cfg_i.index)
        bpes_pkg::CFG_BOX_LENGTH: box_d       = cfg_i.data[CW-1:0];
        bpes_pkg::CFG_ROW_FIRST:  row_first_d = cfg_i.data[bpes_pkg::ROW_W-1:0];
        bpes_pkg::CFG_ROW_END:    row_end_d   = cfg_i.data[bpes_pkg::ROW_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bpes_pkg::S_IDLE: begin
        if (atom_i.valid) begin
          if (ram_we) begin
            loaded_d = loaded_q + 1'b1;
          end
          if (atom_i.last_atom) begin
            i_d     = bpes_pkg::CNT_W'(row_first_q);
            state_d = bpes_pkg::S_ROW;
          end
        end
      end
      bpes_pkg::S_ROW: begin
        ram_raddr = i_q[bpes_pkg::IDX_W-1:0];
        state_d   = (i_q < end_w) ? bpes_pkg::S_ROW_LATCH : bpes_pkg::S_DONE;
      end
      bpes_pkg::S_ROW_LATCH: begin
        ai_d    = ram_rdata;
        j_d     = i_q + 1'b1;
        state_d = bpes_pkg::S_COL;
      end
      bpes_pkg::S_COL: begin
        if (j_q < loaded_q) begin
          state_d = bpes_pkg::S_PAIR;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = bpes_pkg::S_ROW;
        end
      end
      bpes_pkg::S_PAIR: begin
        aj_d   = ram_rdata;
        oo_d   = ai_q[bpes_pkg::WORD_W-1] & ram_rdata[bpes_pkg::WORD_W-1];
        axis_d = 2'd0;
        if (!(ai_q[bpes_pkg::WORD_W-1] | ram_rdata[bpes_pkg::WORD_W-1]) || sat_q) begin
          j_d     = j_q + 1'b1;
          state_d = bpes_pkg::S_COL;
        end else begin
          state_d = bpes_pkg::S_GAP;
        end
      end
      bpes_pkg::S_GAP: begin
        gap_d = gdiff;
        if (box_q == '0) begin
          state_d = bpes_pkg::S_GAP_CHK;
        end else begin
          div_n_d   = {gdiff, {(bpes_pkg::DIV_W - CW){1'b0}}};
          div_den_d = bpes_pkg::REM_W'(box_q);
          div_rem_d = '0;
          div_quo_d = '0;
          div_ovf_d = 1'b0;
          div_cnt_d = bpes_pkg::DCNT_W'(CW);
          ret_d     = bpes_pkg::S_FOLD;
          state_d   = bpes_pkg::S_DIV;
        end
      end
      bpes_pkg::S_FOLD: begin
        gap_d   = ({grem, 1'b0} < {1'b0, box_q}) ? grem : box_q - grem;
        state_d = bpes_pkg::S_GAP_CHK;
      end
      bpes_pkg::S_GAP_CHK: begin
        if (gap_q >= bpes_pkg::CUT_AXIS) begin
          j_d     = j_q + 1'b1;
          state_d = bpes_pkg::S_COL;
        end else begin
          mul_a_d = 32'(gap_q);
          mul_b_d = 32'(gap_q);
          ret_d   = bpes_pkg::S_GAP_ACC;
          state_d = bpes_pkg::S_MUL;
        end
      end
      bpes_pkg::S_GAP_ACC: begin
        r2_d = ((axis_q == 2'd0) ? '0 : r2_q) + prod_q[bpes_pkg::REM_W-1:0];
        if (axis_q == 2'd2) begin
          state_d = bpes_pkg::S_R_CHK;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = bpes_pkg::S_GAP;
        end
      end
      bpes_pkg::S_R_CHK: begin
        if (r2_q >= bpes_pkg::CUT_SQ) begin
          j_d     = j_q + 1'b1;
          state_d = bpes_pkg::S_COL;
        end else if (r2_q == '0) begin
          sum_d   = {1'b1, {(bpes_pkg::ENERGY_W-1){1'b0}}};
          sat_d   = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = bpes_pkg::S_COL;
        end else begin
          sq_v_d   = {r2_q[37:0], 16'd0};
          sq_res_d = '0;
          sq_bit_d = 56'd1 << 54;
          sq_cnt_d = 5'd27;
          state_d  = bpes_pkg::S_SQRT;
        end
      end
      bpes_pkg::S_SQRT: begin
        if (sq_sum >= sq_res_q + sq_bit_q) begin
          sq_v_d   = 54'(sq_sum - (sq_res_q + sq_bit_q));
          sq_res_d = (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        sq_cnt_d = sq_cnt_q - 1'b1;
        if (sq_cnt_q == '0) begin
          state_d = bpes_pkg::S_Z_LO;
        end
      end
      bpes_pkg::S_Z_LO: begin
        mul_a_d = 32'(sq_res_q[26:0]);
        mul_b_d = k_sel[31:0];
        ret_d   = bpes_pkg::S_Z_HI;
        state_d = bpes_pkg::S_MUL;
      end
      bpes_pkg::S_Z_HI: begin
        acc_d   = prod_q;
        mul_b_d = k_sel[63:32];
        ret_d   = bpes_pkg::S_Z_SUM;
        state_d = bpes_pkg::S_MUL;
      end
      bpes_pkg::S_Z_SUM: begin
        n_d     = full_w[61:56];
        f_d     = full_w[55:24];
        m_d     = 32'h8000_0000;
        k_d     = 6'd1;
        state_d = bpes_pkg::S_EXP;
      end
      bpes_pkg::S_EXP: begin
        if (k_q == 6'd33) begin
          state_d = bpes_pkg::S_F_LO;
        end else if (f_q[31]) begin
          mul_a_d = m_q;
          mul_b_d = bpes_pkg::HALF_POW[k_q];
          ret_d   = bpes_pkg::S_EXP_UPD;
          state_d = bpes_pkg::S_MUL;
        end else begin
          f_d = f_q << 1;
          k_d = k_q + 1'b1;
        end
      end
      bpes_pkg::S_EXP_UPD: begin
        m_d     = prod_q[62:31];
        f_d     = f_q << 1;
        k_d     = k_q + 1'b1;
        state_d = bpes_pkg::S_EXP;
      end
      bpes_pkg::S_F_LO: begin
        mul_a_d = {5'd0, m_q[31:5]};
        mul_b_d = p_sel[31:0];
        ret_d   = bpes_pkg::S_F_HI;
        state_d = bpes_pkg::S_MUL;
      end
      bpes_pkg::S_F_HI: begin
        acc_d   = prod_q;
        mul_b_d = p_sel[63:32];
        ret_d   = bpes_pkg::S_F_SUM;
        state_d = bpes_pkg::S_MUL;
      end
      bpes_pkg::S_F_SUM: begin
        e_d       = shamt[6] ? '0 : full_w >> shamt[5:0];
        div_n_d   = {(oo_q ? bpes_pkg::C_OO[bpes_pkg::QUO_W-1:0]
                           : bpes_pkg::C_SIO[bpes_pkg::QUO_W-1:0]), 32'd0};
        div_den_d = r2_q;
        div_rem_d = '0;
        div_quo_d = '0;
        div_ovf_d = 1'b0;
        div_cnt_d = bpes_pkg::DCNT_W'(bpes_pkg::DIV_W);
        dcnt_d    = 2'd0;
        ret_d     = bpes_pkg::S_D_NEXT;
        state_d   = bpes_pkg::S_DIV;
      end
      bpes_pkg::S_DIV: begin
        if (div_trial >= {1'b0, div_den_q}) begin
          div_rem_d = bpes_pkg::REM_W'(div_trial - {1'b0, div_den_q});
          div_quo_d = {div_quo_q[bpes_pkg::QUO_W-2:0], 1'b1};
        end else begin
          div_rem_d = div_trial[bpes_pkg::REM_W-1:0];
          div_quo_d = {div_quo_q[bpes_pkg::QUO_W-2:0], 1'b0};
        end
        div_ovf_d = div_ovf_q | div_quo_q[bpes_pkg::QUO_W-1];
        div_n_d   = div_n_q << 1;
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == bpes_pkg::DCNT_W'(1)) begin
          state_d = ret_q;
        end
      end
      bpes_pkg::S_D_NEXT: begin
        if (dcnt_q == 2'd2) begin
          d_d     = quo_cap;
          state_d = bpes_pkg::S_ACC;
        end else begin
          dcnt_d    = dcnt_q + 1'b1;
          div_n_d   = {quo_cap, 32'd0};
          div_rem_d = '0;
          div_quo_d = '0;
          div_ovf_d = 1'b0;
          div_cnt_d = bpes_pkg::DCNT_W'(bpes_pkg::DIV_W);
          state_d   = bpes_pkg::S_DIV;
        end
      end
      bpes_pkg::S_ACC: begin
        if (term_w < MIN66) begin
          sum_d = MIN66[bpes_pkg::ENERGY_W-1:0];
          sat_d = 1'b1;
        end else if (snew_w > MAX66) begin
          sum_d = MAX66[bpes_pkg::ENERGY_W-1:0];
          sat_d = 1'b1;
        end else if (snew_w < MIN66) begin
          sum_d = MIN66[bpes_pkg::ENERGY_W-1:0];
          sat_d = 1'b1;
        end else begin
          sum_d = snew_w[bpes_pkg::ENERGY_W-1:0];
        end
        j_d     = j_q + 1'b1;
        state_d = bpes_pkg::S_COL;
      end
      bpes_pkg::S_MUL: begin
        state_d = ret_q;
      end
      bpes_pkg::S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          energy_d    = sum_q;
          sat_out_d   = sat_q;
          sum_d       = '0;
          sat_d       = 1'b0;
          loaded_d    = '0;
          state_d     = bpes_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpes_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpes_pkg::S_IDLE;
      ret_q       <= bpes_pkg::S_IDLE;
      loaded_q    <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      box_q       <= bpes_pkg::BOX_RESET;
      row_first_q <= '0;
      row_end_q   <= bpes_pkg::ROW_END_RESET;
      i_q         <= '0;
      j_q         <= '0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      loaded_q    <= loaded_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      box_q       <= box_d;
      row_first_q <= row_first_d;
      row_end_q   <= row_end_d;
      i_q         <= i_d;
      j_q         <= j_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    energy_q  <= energy_d;
    sat_out_q <= sat_out_d;
    ai_q      <= ai_d;
    aj_q      <= aj_d;
    oo_q      <= oo_d;
    axis_q    <= axis_d;
    dcnt_q    <= dcnt_d;
    gap_q     <= gap_d;
    r2_q      <= r2_d;
    sq_v_q    <= sq_v_d;
    sq_res_q  <= sq_res_d;
    sq_bit_q  <= sq_bit_d;
    sq_cnt_q  <= sq_cnt_d;
    acc_q     <= acc_d;
    n_q       <= n_d;
    f_q       <= f_d;
    m_q       <= m_d;
    k_q       <= k_d;
    e_q       <= e_d;
    d_q       <= d_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    prod_q    <= 64'(mul_a_q) * 64'(mul_b_q);
    div_n_q   <= div_n_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_quo_q <= div_quo_d;
    div_ovf_q <= div_ovf_d;
  end

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpes_pkg::S_DIV |-> div_cnt_q != '0)
    else $error("divider running with zero step count");

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q && state_q != bpes_pkg::S_DONE |=> sat_q)
    else $error("saturation flag dropped inside a set");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpes_pkg::S_PAIR |-> (i_q < j_q) && (j_q < loaded_q))
    else $error("pair indices out of order or beyond the set");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= bpes_pkg::CNT_W'(bpes_pkg::MAX_ATOMS))
    else $error("atom count beyond store depth");

endmodule
